FILE: rtl/core/gsfp_pkg.sv
// gsfp_pkg: shared constants and types for the gas sensor frame parser
// no dependencies; used by gsfp_parse, gas_sensor_frame_parser_top and the testbench
package gsfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 16;
    localparam int POS_W       = 4;
    localparam int PAYLOAD_N   = 6;
    localparam int PAYLOAD_IDX_W = 3;
    localparam int CFG_IDX_W   = 2;

    // reset values of the header registers
    localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'h2C;
    localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'hE4;

    // frame byte positions (index of the next byte)
    localparam logic [POS_W-1:0] POS_HDR_FIRST  = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR_SECOND = 4'd1;
    localparam logic [POS_W-1:0] POS_PAYLOAD_LO = 4'd2;
    localparam logic [POS_W-1:0] POS_CHECKSUM   = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 2'd1;

    // frame status codes
    localparam logic STATUS_GOOD     = 1'b0;
    localparam logic STATUS_CSUM_ERR = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] tvoc_raw;
        logic [VALUE_W-1:0] ch2o_raw;
        logic [VALUE_W-1:0] co2_ppm;
        logic               frame_status;
    } t_frame_result;

endpackage

FILE: rtl/core/gas_sensor_frame_parser_top.sv
// gas_sensor_frame_parser_top: nine-byte sensor frame parser, top level
// depends on gsfp_pkg and gsfp_parse
//
// Takes received serial bytes, one per input transaction, and parses frames of
// two header bytes (programmable, 0x2C and 0xE4 after reset), six payload bytes
// and an 8-bit additive checksum. Every completed frame gives one output
// transaction carrying the big-endian TVOC, CH2O and CO2 words and a status bit
// (0 checksum good, 1 checksum mismatch); header mismatches drop the byte
// silently and restart the search. The block accepts one byte per clock while
// no finished result is held back by the output: each byte is registered in an
// input register, then a single pass of compare and add logic updates the frame
// state and loads the output register when the byte closes a frame. Output
// stalls only hold back input when a finished result is still waiting. Header
// registers are written through the configuration channel (index 0 first
// header, index 1 second header, other indexes ignored), which is always ready
// and should be used while the parser is idle.
module gas_sensor_frame_parser_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [gsfp_pkg::BYTE_W-1:0]     i_rx_byte,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gsfp_pkg::VALUE_W-1:0]    o_tvoc_raw,
    output logic [gsfp_pkg::VALUE_W-1:0]    o_ch2o_raw,
    output logic [gsfp_pkg::VALUE_W-1:0]    o_co2_ppm,
    output logic                            o_frame_status,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gsfp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gsfp_pkg::BYTE_W-1:0]     i_cfg_data
);
    import gsfp_pkg::*;

    // header registers
    logic [BYTE_W-1:0] r_hdr_first;
    logic [BYTE_W-1:0] r_hdr_second;

    // input register stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_tvoc;
    logic [VALUE_W-1:0] r_ch2o;
    logic [VALUE_W-1:0] r_co2;
    logic               r_status;

    t_frame_result parse_res;
    logic          step;
    logic          load_out;

    // the held byte moves on unless it closes a frame while the output is full
    assign step     = r_in_valid && (!parse_res.valid || !r_out_valid || i_out_ready);
    assign load_out = step && parse_res.valid;

    assign o_in_ready  = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    gsfp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_hdr_first  (r_hdr_first),
        .i_hdr_second (r_hdr_second),
        .o_result     (parse_res)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= HDR_FIRST_RST;
            r_hdr_second <= HDR_SECOND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HDR_FIRST:  r_hdr_first  <= i_cfg_data;
                CFG_HDR_SECOND: r_hdr_second <= i_cfg_data;
                default: ;      // unused index, write dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_tvoc   <= parse_res.tvoc_raw;
            r_ch2o   <= parse_res.ch2o_raw;
            r_co2    <= parse_res.co2_ppm;
            r_status <= parse_res.frame_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_tvoc_raw     = r_tvoc;
    assign o_ch2o_raw     = r_ch2o;
    assign o_co2_ppm      = r_co2;
    assign o_frame_status = r_status;

endmodule

FILE: rtl/core/gsfp_parse.sv
// gsfp_parse: frame position tracking, running checksum and payload store
// depends on gsfp_pkg
module gsfp_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [gsfp_pkg::BYTE_W-1:0]   i_byte,
    input  logic [gsfp_pkg::BYTE_W-1:0]   i_hdr_first,
    input  logic [gsfp_pkg::BYTE_W-1:0]   i_hdr_second,
    output gsfp_pkg::t_frame_result       o_result
);
    import gsfp_pkg::*;

    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         n_pos;
    logic [BYTE_W-1:0]        r_sum;
    logic [BYTE_W-1:0]        n_sum;
    logic [BYTE_W-1:0]        r_payload [PAYLOAD_N];
    logic                     payload_wr;
    logic [POS_W-1:0]         wr_off;
    logic [PAYLOAD_IDX_W-1:0] wr_idx;

    assign wr_off = r_pos - POS_PAYLOAD_LO;
    assign wr_idx = wr_off[PAYLOAD_IDX_W-1:0];

    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        payload_wr = 1'b0;
        priority if (r_pos == POS_HDR_FIRST) begin
            if (i_byte == i_hdr_first) begin
                n_sum = i_byte;
                n_pos = POS_HDR_SECOND;
            end
        end else if (r_pos == POS_HDR_SECOND) begin
            if (i_byte == i_hdr_second) begin
                n_sum = r_sum + i_byte;
                n_pos = POS_PAYLOAD_LO;
            end else begin
                n_pos = POS_HDR_FIRST;
            end
        end else if (r_pos < POS_CHECKSUM) begin
            payload_wr = 1'b1;
            n_sum      = r_sum + i_byte;
            n_pos      = r_pos + 1'b1;
        end else begin
            // checksum byte, or an unreachable position
            n_pos = POS_HDR_FIRST;
        end
    end

    // result is offered whenever the next byte closes a frame
    always_comb begin
        o_result.valid        = (r_pos == POS_CHECKSUM);
        o_result.tvoc_raw     = {r_payload[0], r_payload[1]};
        o_result.ch2o_raw     = {r_payload[2], r_payload[3]};
        o_result.co2_ppm      = {r_payload[4], r_payload[5]};
        o_result.frame_status = (r_sum == i_byte) ? STATUS_GOOD : STATUS_CSUM_ERR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HDR_FIRST;
            r_sum <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && payload_wr) begin
            r_payload[wr_idx] <= i_byte;
        end
    end

endmodule

FILE: tb/gsfp_frame_checker.sv
// gsfp_frame_checker: watches the byte, result and configuration channels,
// predicts each frame result and compares it; depends on gsfp_pkg
`timescale 1ns / 100ps

module gsfp_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [gsfp_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [gsfp_pkg::VALUE_W-1:0]    i_tvoc_raw,
    input  logic [gsfp_pkg::VALUE_W-1:0]    i_ch2o_raw,
    input  logic [gsfp_pkg::VALUE_W-1:0]    i_co2_ppm,
    input  logic                            i_frame_status,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [gsfp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gsfp_pkg::BYTE_W-1:0]     i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import gsfp_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] tvoc_raw;
        logic [VALUE_W-1:0] ch2o_raw;
        logic [VALUE_W-1:0] co2_ppm;
        logic               frame_status;
    } t_frame_rec;

    t_frame_rec        expected_frames[$];
    logic [BYTE_W-1:0] hdr_first;
    logic [BYTE_W-1:0] hdr_second;
    logic [POS_W-1:0]  frame_pos;
    logic [BYTE_W-1:0] frame_sum;
    logic [BYTE_W-1:0] payload_mem [PAYLOAD_N];
    int                mismatch_cnt = 0;

    // advance the frame state by one byte, queue a result on the checksum byte
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        t_frame_rec rec;
        if (frame_pos == POS_HDR_FIRST) begin
            if (b == hdr_first) begin
                frame_sum = b;
                frame_pos = POS_HDR_SECOND;
            end
        end else if (frame_pos == POS_HDR_SECOND) begin
            // a wrong second header drops the byte, no re-test as first header
            if (b == hdr_second) begin
                frame_sum = frame_sum + b;
                frame_pos = POS_PAYLOAD_LO;
            end else begin
                frame_pos = POS_HDR_FIRST;
            end
        end else if (frame_pos < POS_CHECKSUM) begin
            payload_mem[frame_pos - POS_PAYLOAD_LO] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 1'b1;
        end else begin
            rec.tvoc_raw     = {payload_mem[0], payload_mem[1]};
            rec.ch2o_raw     = {payload_mem[2], payload_mem[3]};
            rec.co2_ppm      = {payload_mem[4], payload_mem[5]};
            rec.frame_status = (frame_sum == b) ? STATUS_GOOD : STATUS_CSUM_ERR;
            expected_frames.push_back(rec);
            frame_pos = POS_HDR_FIRST;
        end
    endtask

    task automatic check_result();
        t_frame_rec rec;
        if (expected_frames.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: result with no frame pending: tvoc %h ch2o %h co2 %h st %b",
                         $time, i_tvoc_raw, i_ch2o_raw, i_co2_ppm, i_frame_status);
        end else begin
            rec = expected_frames.pop_front();
            if (i_tvoc_raw !== rec.tvoc_raw || i_ch2o_raw !== rec.ch2o_raw ||
                i_co2_ppm !== rec.co2_ppm || i_frame_status !== rec.frame_status) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("%0t: frame mismatch exp tvoc %h ch2o %h co2 %h st %b",
                             $time, rec.tvoc_raw, rec.ch2o_raw, rec.co2_ppm,
                             rec.frame_status);
                    $display("%0t:                got tvoc %h ch2o %h co2 %h st %b",
                             $time, i_tvoc_raw, i_ch2o_raw, i_co2_ppm, i_frame_status);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hdr_first  = HDR_FIRST_RST;
            hdr_second = HDR_SECOND_RST;
            frame_pos  = POS_HDR_FIRST;
            frame_sum  = '0;
            expected_frames.delete();
        end else begin
            // result first: it can never belong to a byte taken at this edge
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HDR_FIRST:  hdr_first  = i_cfg_data;
                    CFG_HDR_SECOND: hdr_second = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                parse_byte(i_rx_byte);
        end
        o_pending    <= expected_frames.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

FILE: tb/tb_gas_sensor_frame_parser_top.sv
// tb_gas_sensor_frame_parser_top: stimulus and verdict for the frame parser
// depends on gsfp_pkg, gas_sensor_frame_parser_top and gsfp_frame_checker
`timescale 1ns / 100ps

module tb_gas_sensor_frame_parser_top;
    import gsfp_pkg::*;

    // spare register indexes, the block ignores writes to them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // cycles to let a byte that gives no result clear the input register
    localparam int DRAIN_CYCLES = 6;
    localparam int FRAME_LEN    = 9;

    typedef enum {FR_GOOD, FR_BAD_CSUM, FR_BAD_HDR, FR_TRUNC} t_frame_kind;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EDGE} t_fill;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte    = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [VALUE_W-1:0]   tvoc_raw;
    logic [VALUE_W-1:0]   ch2o_raw;
    logic [VALUE_W-1:0]   co2_ppm;
    logic                 frame_status;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [BYTE_W-1:0]    cfg_data   = '0;

    int                   fail_count;
    int                   pending;

    // header values the frame builder uses, tracks what was written
    logic [BYTE_W-1:0]    hdr_first_cur  = HDR_FIRST_RST;
    logic [BYTE_W-1:0]    hdr_second_cur = HDR_SECOND_RST;
    // set for the last part of the run: no gaps, no stalls
    bit                   quiet = 1'b0;
    int                   frame_bytes_sent = 0;
    int                   ready_left = 0;

    gas_sensor_frame_parser_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_tvoc_raw     (tvoc_raw),
        .o_ch2o_raw     (ch2o_raw),
        .o_co2_ppm      (co2_ppm),
        .o_frame_status (frame_status),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    gsfp_frame_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_tvoc_raw     (tvoc_raw),
        .i_ch2o_raw     (ch2o_raw),
        .i_co2_ppm      (co2_ppm),
        .i_frame_status (frame_status),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random bursts of ready or stall, mostly ready
    always @(posedge clk) begin
        if (quiet) begin
            out_ready <= 1'b1;
        end else if (ready_left == 0) begin
            out_ready  <= ($urandom_range(0, 3) != 0);
            ready_left <= $urandom_range(1, 17);
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // one byte transaction; valid stays high across back-to-back bytes, and this
    // task drops it only when a gap burst is inserted in front of this byte
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold the sender until every expected result is out and the input
    // register has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register writes only with the pipeline empty
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HDR_FIRST)
            hdr_first_cur = val;
        else if (idx == CFG_HDR_SECOND)
            hdr_second_cur = val;
    endtask

    // build a nine-byte frame for the current headers, optionally broken
    task automatic send_frame(input t_frame_kind kind, input t_fill fill);
        logic [BYTE_W-1:0] fb [FRAME_LEN];
        logic [BYTE_W-1:0] sum;
        int                cut;
        int                hk;
        fb[0] = hdr_first_cur;
        fb[1] = hdr_second_cur;
        for (int k = 2; k < FRAME_LEN - 1; k++) begin
            case (fill)
                FILL_ZERO: fb[k] = '0;
                FILL_ONES: fb[k] = '1;
                FILL_EDGE: fb[k] = ($urandom_range(0, 1) != 0) ? '1 : '0;
                default:   fb[k] = BYTE_W'($urandom_range(0, 255));
            endcase
        end
        sum = '0;
        for (int k = 0; k < FRAME_LEN - 1; k++)
            sum = sum + fb[k];
        fb[FRAME_LEN-1] = sum;
        cut = FRAME_LEN;
        case (kind)
            FR_BAD_CSUM: fb[FRAME_LEN-1] = sum + BYTE_W'($urandom_range(1, 255));
            FR_BAD_HDR: begin
                hk     = $urandom_range(0, 1);
                fb[hk] = fb[hk] ^ BYTE_W'($urandom_range(1, 255));
            end
            FR_TRUNC:    cut = $urandom_range(1, FRAME_LEN - 1);
            default: ;
        endcase
        for (int k = 0; k < cut; k++)
            send_byte(fb[k]);
        frame_bytes_sent += cut;
    endtask

    // mostly well-formed frames with random content, the rest broken frames
    // and loose noise bytes; noise does not count toward the phase size
    task automatic run_phase(input int n_bytes);
        int start_cnt;
        int pick;
        start_cnt = frame_bytes_sent;
        while (frame_bytes_sent - start_cnt < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(FR_GOOD, FILL_RANDOM);
            else if (pick < 60)
                send_frame(FR_GOOD, FILL_EDGE);
            else if (pick < 72)
                send_frame(FR_BAD_CSUM, FILL_RANDOM);
            else if (pick < 80)
                send_frame(FR_BAD_HDR, FILL_RANDOM);
            else if (pick < 88)
                send_frame(FR_TRUNC, FILL_RANDOM);
            else if (pick < 92)
                send_byte(hdr_first_cur);
            else
                send_byte(BYTE_W'($urandom_range(0, 255)));
            // now and then let the block run dry before going on
            if (!quiet && $urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    initial begin
        int guard;
        guard = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: first header twice, so the second is a bad second header
        // that must not restart the frame; then a stray second header byte
        send_byte(hdr_first_cur);
        send_byte(hdr_first_cur);
        send_byte(hdr_second_cur);
        // all-ones payload, checksum wraps
        send_frame(FR_GOOD, FILL_ONES);
        // wrong first header byte is dropped
        send_byte(8'h00);
        // all-zero payload with a wrong checksum still gives a result
        send_frame(FR_BAD_CSUM, FILL_ZERO);

        // random phases under several header settings, extremes included;
        // a phase can end mid-frame, so some writes land between frame bytes
        run_phase(200);
        write_reg(CFG_HDR_FIRST, 8'h00);
        write_reg(CFG_HDR_SECOND, 8'hFF);
        run_phase(200);
        write_reg(CFG_HDR_FIRST, 8'hFF);
        write_reg(CFG_HDR_SECOND, 8'h00);
        run_phase(200);
        // writes to the spare indexes change nothing
        write_reg(CFG_SPARE_A, BYTE_W'($urandom_range(0, 255)));
        write_reg(CFG_SPARE_B, BYTE_W'($urandom_range(0, 255)));
        run_phase(150);
        // equal headers
        write_reg(CFG_HDR_FIRST, 8'hA5);
        write_reg(CFG_HDR_SECOND, 8'hA5);
        run_phase(200);
        write_reg(CFG_HDR_FIRST, BYTE_W'($urandom_range(0, 255)));
        write_reg(CFG_HDR_SECOND, BYTE_W'($urandom_range(0, 255)));
        run_phase(200);
        // back to the reset headers, full rate on both sides
        write_reg(CFG_HDR_FIRST, HDR_FIRST_RST);
        write_reg(CFG_HDR_SECOND, HDR_SECOND_RST);
        quiet = 1'b1;
        run_phase(250);

        // drain and give the last bytes time to clear
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
